// ===== design/bellman_ford_distance_to_target_macros.svh =====
// assertion macros used by the checker file
`ifndef BELLMAN_FORD_DISTANCE_TO_TARGET_MACROS_SVH
`define BELLMAN_FORD_DISTANCE_TO_TARGET_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BFDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BFDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bfdt_pkg.sv =====
// shared types, widths and codes of the distance-to-target block
package bfdt_pkg;

  // field widths
  localparam int NodeW  = 6;
  localparam int LenW   = 24;
  localparam int CostW  = 16;
  localparam int DistW  = 32;
  localparam int ProdW  = LenW + CostW;
  localparam int CntW   = 7;
  localparam int MaskW  = 64;

  // stream payload widths, padded to whole bytes
  localparam int SDataW = 56;
  localparam int MDataW = 40;

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_NODE_COUNT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_MASK = 1'b1;

  // reset values and parameter defaults
  localparam logic [CntW-1:0]  NodeCountRst  = 7'd64;
  localparam logic [DistW-1:0] DistUnreach   = '1;
  localparam int               MaxNodesDef   = 64;
  localparam int               MaxEdgesDef   = 256;

  // one stored edge
  typedef struct packed {
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [LenW-1:0]  len;
    logic [CostW-1:0] cost;
    logic             open;
  } edge_t;

  // one distance table entry
  typedef struct packed {
    logic             ok;
    logic [DistW-1:0] val;
  } dist_entry_t;

  // requests from the sequencer to the distance table
  typedef struct packed {
    logic             clear;
    logic             rd;
    logic [NodeW-1:0] rd_a;
    logic [NodeW-1:0] rd_b;
    logic             wr;
    logic [NodeW-1:0] wr_addr;
    dist_entry_t      wdata;
  } dist_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_EDGE_CHK,
    ST_DIST_RD,
    ST_UPDATE,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } state_e;

endpackage

// ===== design/bellman_ford_distance_to_target.sv =====
// top level: shortest distance from every node to a target set by edge relaxation
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/tready        edge: tdata, tuser open, tlast last
//   m_axis    out        m_axis_tvalid/tready        distance: tdata, tuser reach, tlast
//   cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// loading takes one edge per cycle, storing up to MAX_EDGES in the edge store
// the item with tlast starts a run: a setup state, then passes over the stored edges
//   (each a read of the edge store, a read of the distance table and a write back if
//   shorter), at most node_count passes, ending after a pass with no change
// results follow in node order, each after the last is taken; no edge taken meanwhile
// reset clears control state and the written bits of the distance table
module bellman_ford_distance_to_target
  import bfdt_pkg::*;
#(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // edges
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SDataW-1:0]  s_axis_tdata,  // from_node, to_node, length, cost_factor
  input  logic               s_axis_tuser,  // edge_open
  input  logic               s_axis_tlast,
  // distances
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MDataW-1:0]  m_axis_tdata,  // node_index, distance
  output logic               m_axis_tuser,  // reachable
  output logic               m_axis_tlast,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MaskW-1:0]   cfg_data_i
);

  localparam int EdgeAw = $clog2(MAX_EDGES);

  logic [CntW-1:0]      node_count_q;
  logic [MaskW-1:0]     target_mask_q;
  logic [CntW-1:0]      n_act;
  logic [MAX_NODES-1:0] init_mask;
  edge_t                edge_in, edge_rd;
  logic                 edge_wr_en, edge_rd_en;
  logic [EdgeAw-1:0]    edge_wr_addr, edge_rd_addr;
  dist_req_t            dist_req;
  dist_entry_t          dist_a, dist_b;
  logic [NodeW-1:0]     out_node;
  logic [DistW-1:0]     out_dist;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NodeCountRst;
      target_mask_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT:  node_count_q  <= cfg_data_i[CntW-1:0];
        CFG_TARGET_MASK: target_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // nodes in use and their start state
  assign n_act = (node_count_q > CntW'(MAX_NODES)) ? CntW'(MAX_NODES) : node_count_q;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      init_mask[i] = target_mask_q[i] && (CntW'(i) < n_act);
    end
  end

  // edge unpacking
  assign edge_in.src  = s_axis_tdata[NodeW-1:0];
  assign edge_in.dst  = s_axis_tdata[2*NodeW-1:NodeW];
  assign edge_in.len  = s_axis_tdata[2*NodeW+LenW-1:2*NodeW];
  assign edge_in.cost = s_axis_tdata[2*NodeW+LenW+CostW-1:2*NodeW+LenW];
  assign edge_in.open = s_axis_tuser;

  bfdt_edge_mem #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_mem (
    .clk_i     (clk_i),
    .wr_en_i   (edge_wr_en),
    .wr_addr_i (edge_wr_addr),
    .wr_data_i (edge_in),
    .rd_en_i   (edge_rd_en),
    .rd_addr_i (edge_rd_addr),
    .rd_data_o (edge_rd)
  );

  bfdt_dist_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_dist_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_mask_i (init_mask),
    .req_i       (dist_req),
    .rd_a_o      (dist_a),
    .rd_b_o      (dist_b)
  );

  bfdt_relax #(
    .MAX_EDGES (MAX_EDGES)
  ) u_relax (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .n_act_i        (n_act),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_last_i      (s_axis_tlast),
    .edge_wr_en_o   (edge_wr_en),
    .edge_wr_addr_o (edge_wr_addr),
    .edge_rd_en_o   (edge_rd_en),
    .edge_rd_addr_o (edge_rd_addr),
    .edge_rd_i      (edge_rd),
    .dist_req_o     (dist_req),
    .dist_a_i       (dist_a),
    .dist_b_i       (dist_b),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_node_o     (out_node),
    .out_dist_o     (out_dist),
    .out_ok_o       (m_axis_tuser),
    .out_last_o     (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {(MDataW - NodeW - DistW)'(0), out_dist, out_node};

endmodule

// ===== design/bfdt_edge_mem.sv =====
// edge store: one write port, one registered read port
module bfdt_edge_mem
  import bfdt_pkg::*;
#(
  parameter int MAX_EDGES = MaxEdgesDef,
  localparam int EdgeAw   = $clog2(MAX_EDGES)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [EdgeAw-1:0] wr_addr_i,
  input  edge_t             wr_data_i,
  input  logic              rd_en_i,
  input  logic [EdgeAw-1:0] rd_addr_i,
  output edge_t             rd_data_o
);

  edge_t mem [MAX_EDGES];
  edge_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/bfdt_dist_mem.sv =====
// distance table: two registered read ports, one write port, per-entry written bits
module bfdt_dist_mem
  import bfdt_pkg::*;
#(
  parameter int MAX_NODES = MaxNodesDef,
  localparam int NodeAw   = $clog2(MAX_NODES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [MAX_NODES-1:0] init_mask_i,
  input  dist_req_t            req_i,
  output dist_entry_t          rd_a_o,
  output dist_entry_t          rd_b_o
);

  dist_entry_t          mem [MAX_NODES];
  logic [MAX_NODES-1:0] written_q;
  dist_entry_t          rd_a_q, rd_b_q;
  logic                 hit_a_q, hit_b_q;
  logic                 init_a_q, init_b_q;
  logic [NodeAw-1:0]    addr_a, addr_b, addr_w;

  assign addr_a = req_i.rd_a[NodeAw-1:0];
  assign addr_b = req_i.rd_b[NodeAw-1:0];
  assign addr_w = req_i.wr_addr[NodeAw-1:0];

  // storage write
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[addr_w] <= req_i.wdata;
    end
  end

  // written bits, cleared at the start of each computation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.clear) begin
      written_q <= '0;
    end else if (req_i.wr) begin
      written_q[addr_w] <= 1'b1;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_a_q   <= mem[addr_a];
      rd_b_q   <= mem[addr_b];
      hit_a_q  <= written_q[addr_a];
      hit_b_q  <= written_q[addr_b];
      init_a_q <= init_mask_i[addr_a];
      init_b_q <= init_mask_i[addr_b];
    end
  end

  // unwritten entries read as their start value
  assign rd_a_o = hit_a_q ? rd_a_q : dist_entry_t'{ok: init_a_q,
                                                   val: init_a_q ? '0 : DistUnreach};
  assign rd_b_o = hit_b_q ? rd_b_q : dist_entry_t'{ok: init_b_q,
                                                   val: init_b_q ? '0 : DistUnreach};

endmodule

// ===== design/bfdt_relax.sv =====
// sequencer: edge loading, relaxation passes and result emission
module bfdt_relax
  import bfdt_pkg::*;
#(
  parameter int MAX_EDGES = MaxEdgesDef,
  localparam int EdgeAw   = $clog2(MAX_EDGES),
  localparam int EdgeCw   = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CntW-1:0]   n_act_i,
  // edge input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_last_i,
  // edge store
  output logic              edge_wr_en_o,
  output logic [EdgeAw-1:0] edge_wr_addr_o,
  output logic              edge_rd_en_o,
  output logic [EdgeAw-1:0] edge_rd_addr_o,
  input  edge_t             edge_rd_i,
  // distance table
  output dist_req_t         dist_req_o,
  input  dist_entry_t       dist_a_i,
  input  dist_entry_t       dist_b_i,
  // results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NodeW-1:0]  out_node_o,
  output logic [DistW-1:0]  out_dist_o,
  output logic              out_ok_o,
  output logic              out_last_o
);

  state_e             state_q, state_d;
  logic [EdgeCw-1:0]  edge_total_q, edge_total_d;
  logic [EdgeCw-1:0]  edge_idx_q, edge_idx_d;
  logic [CntW-1:0]    pass_q, pass_d;
  logic               changed_q, changed_d;
  logic [CntW-1:0]    emit_idx_q, emit_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [DistW-1:0]   w_q;
  logic               skip_q;
  logic [NodeW-1:0]   out_node_q;
  logic [DistW-1:0]   out_dist_q;
  logic               out_ok_q, out_last_q;
  logic [ProdW-1:0]   prod;
  logic [DistW:0]     sum;
  logic [DistW-1:0]   cand;
  logic [CntW-1:0]    pass_nx;
  logic               edge_skip;
  logic               in_fire;

  // edge weight: Q16.8 length times Q8.8 cost, back to Q24.8
  assign prod      = ProdW'(edge_rd_i.len) * ProdW'(edge_rd_i.cost);
  assign edge_skip = !edge_rd_i.open
                     || ({1'b0, edge_rd_i.src} >= n_act_i)
                     || ({1'b0, edge_rd_i.dst} >= n_act_i);

  // candidate distance through the edge, saturated
  assign sum     = {1'b0, dist_a_i.val} + {1'b0, w_q};
  assign cand    = sum[DistW] ? DistUnreach : sum[DistW-1:0];
  assign pass_nx = pass_q + CntW'(1);
  assign in_fire = in_valid_i && (state_q == ST_LOAD);

  // next state and outputs
  always_comb begin
    state_d        = state_q;
    edge_total_d   = edge_total_q;
    edge_idx_d     = edge_idx_q;
    pass_d         = pass_q;
    changed_d      = changed_q;
    emit_idx_d     = emit_idx_q;
    out_valid_d    = out_valid_q;
    in_ready_o     = 1'b0;
    edge_wr_en_o   = 1'b0;
    edge_wr_addr_o = edge_total_q[EdgeAw-1:0];
    edge_rd_en_o   = 1'b0;
    edge_rd_addr_o = edge_idx_q[EdgeAw-1:0];
    dist_req_o     = '0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          if (edge_total_q < EdgeCw'(MAX_EDGES)) begin
            edge_wr_en_o = 1'b1;
            edge_total_d = edge_total_q + EdgeCw'(1);
          end
          if (in_last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        dist_req_o.clear = 1'b1;
        pass_d           = '0;
        changed_d        = 1'b0;
        edge_idx_d       = '0;
        if (n_act_i == '0) begin
          edge_total_d = '0;
          state_d      = ST_LOAD;
        end else begin
          state_d = ST_EDGE_CHK;
        end
      end
      ST_EDGE_CHK: begin
        if (edge_idx_q == edge_total_q) begin
          state_d = ST_PASS_END;
        end else begin
          edge_rd_en_o = 1'b1;
          state_d      = ST_DIST_RD;
        end
      end
      ST_DIST_RD: begin
        dist_req_o.rd   = 1'b1;
        dist_req_o.rd_a = edge_rd_i.dst;
        dist_req_o.rd_b = edge_rd_i.src;
        state_d         = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!skip_q && dist_a_i.ok && (!dist_b_i.ok || cand < dist_b_i.val)) begin
          dist_req_o.wr        = 1'b1;
          dist_req_o.wr_addr   = edge_rd_i.src;
          dist_req_o.wdata.ok  = 1'b1;
          dist_req_o.wdata.val = cand;
          changed_d            = 1'b1;
        end
        edge_idx_d = edge_idx_q + EdgeCw'(1);
        state_d    = ST_EDGE_CHK;
      end
      ST_PASS_END: begin
        pass_d = pass_nx;
        if (changed_q && pass_nx < n_act_i) begin
          changed_d  = 1'b0;
          edge_idx_d = '0;
          state_d    = ST_EDGE_CHK;
        end else begin
          emit_idx_d = '0;
          state_d    = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        dist_req_o.rd   = 1'b1;
        dist_req_o.rd_a = emit_idx_q[NodeW-1:0];
        state_d         = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        out_valid_d = 1'b1;
        state_d     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            edge_total_d = '0;
            state_d      = ST_LOAD;
          end else begin
            emit_idx_d = emit_idx_q + CntW'(1);
            state_d    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      edge_total_q <= '0;
      edge_idx_q   <= '0;
      pass_q       <= '0;
      changed_q    <= 1'b0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      edge_idx_q   <= edge_idx_d;
      pass_q       <= pass_d;
      changed_q    <= changed_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // weight and skip decision, result capture
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIST_RD) begin
      w_q    <= prod[ProdW-1:ProdW-DistW];
      skip_q <= edge_skip;
    end
    if (state_q == ST_EMIT_CAP) begin
      out_node_q <= emit_idx_q[NodeW-1:0];
      out_dist_q <= dist_a_i.ok ? dist_a_i.val : DistUnreach;
      out_ok_q   <= dist_a_i.ok;
      out_last_q <= (emit_idx_q + CntW'(1)) == n_act_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_dist_o  = out_dist_q;
  assign out_ok_o    = out_ok_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== design/bfdt_checker.sv =====
// port-level checks of the distance-to-target block and their binding
module bfdt_checker
  import bfdt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast
);

`include "bellman_ford_distance_to_target_macros.svh"

  // a stalled result stays valid and keeps its tdata
  `BFDT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // no edge is taken while results are being delivered
  `BFDT_ASSERT_NOW(a_no_load_in_emit, m_axis_tvalid, !s_axis_tready, "edge accepted during emission")

  // after the final result the block is ready for a new load
  `BFDT_ASSERT_NEXT(a_load_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not ready after last result")

  // an unreachable node reports the saturated distance
  `BFDT_ASSERT_NOW(a_unreach_dist, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[NodeW+DistW-1:NodeW] == DistUnreach, "unreachable node with finite distance")

  // results come in node order
  `BFDT_ASSERT_NOW(a_node_order, m_axis_tvalid && m_axis_tready && !m_axis_tlast, ##3 (m_axis_tvalid && m_axis_tdata[NodeW-1:0] == NodeW'($past(m_axis_tdata[NodeW-1:0], 3) + NodeW'(1))), "result node index out of order")

endmodule

bind bellman_ford_distance_to_target bfdt_checker u_checker (.*);
